/* hw/rtl/tru_pkg.sv */
// Shared widths, reset values, register indexes and byte positions for the record unwrapper.
package tru_pkg;

  localparam int TIME_WRAP_BITS = 12;

  localparam int BYTE_W   = 8;
  localparam int RAW_ID_W = 16;
  localparam int RAW_TS_W = 40;
  localparam int TID_W    = 32;
  localparam int TICKS_W  = 52;
  localparam int NS_W     = 60;
  localparam int PERIOD_W = 20;
  localparam int MARGIN_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  // Product split: low 32 tick bits and the rest, each times the period.
  localparam int LO_W      = 32;
  localparam int HI_W      = TICKS_W - LO_W;
  localparam int LO_PROD_W = LO_W + PERIOD_W;
  localparam int HI_PROD_W = HI_W + PERIOD_W;
  localparam int NS_SHIFT  = 12;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd492752;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd1;

  localparam logic [2:0] POS_FPGA   = 3'd0;
  localparam logic [2:0] POS_ID_LO  = 3'd1;
  localparam logic [2:0] POS_ID_HI  = 3'd2;
  localparam logic [2:0] POS_TS_B0  = 3'd3;
  localparam logic [2:0] POS_TS_B1  = 3'd4;
  localparam logic [2:0] POS_TS_B2  = 3'd5;
  localparam logic [2:0] POS_TS_B3  = 3'd6;
  localparam logic [2:0] POS_LAST   = 3'd7;

  // Result word, last field in the lowest bits.
  typedef struct packed {
    logic [NS_W-1:0]    ns_q4;
    logic [TICKS_W-1:0] ticks;
    logic [TID_W-1:0]   trigger_id;
    logic [BYTE_W-1:0]  fpga_id;
  } result_t;

endpackage

/* hw/rtl/tru_scale.sv */
// Tick-to-nanosecond scaler: two registered partial products and a final add.
module tru_scale
  import tru_pkg::*;
(
  input  logic                clk,
  input  logic                ld,
  input  logic [TICKS_W-1:0]  ticks,
  input  logic [PERIOD_W-1:0] period,
  output logic [NS_W-1:0]     ns_q4
);

  logic [LO_PROD_W-1:0] lo_prod_r;
  logic [HI_PROD_W-1:0] hi_prod_r;
  logic [LO_PROD_W-1:0] lo_prod_nxt;
  logic [HI_PROD_W-1:0] hi_prod_nxt;

  assign lo_prod_nxt = LO_PROD_W'(ticks[LO_W-1:0]) * LO_PROD_W'(period);
  assign hi_prod_nxt = HI_PROD_W'(ticks[TICKS_W-1:LO_W]) * HI_PROD_W'(period);

  always_ff @(posedge clk) begin
    if (ld) begin
      lo_prod_r <= lo_prod_nxt;
      hi_prod_r <= hi_prod_nxt;
    end
  end

  // (hi << 32 - 12) + (lo >> 12), kept to 60 bits
  assign ns_q4 = {hi_prod_r, {(NS_W-HI_PROD_W){1'b0}}}
               + {{(NS_W-(LO_PROD_W-NS_SHIFT)){1'b0}}, lo_prod_r[LO_PROD_W-1:NS_SHIFT]};

endmodule

/* hw/rtl/trigger_record_unwrapper_top.sv */
// Top level: byte assembly, wrap tracking, scaling pipeline and result register.
// A result word passes through stage 1, stage 2 and the result register once the last byte of its record is taken.
// Throughput: one byte word per cycle while in_tready is high; one result per 8-byte record.
// The last byte of a record waits only if all three result stages are full and stalled.
// Reset (rst_n low, synchronous) clears byte position, wrap counters, history and stage
// valids, and loads the period and margin registers with their default values.
module trigger_record_unwrapper_top
  import tru_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input bytes
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [151:0]          out_tdata,  // [7:0] fpga_trigger_id, [39:8] trigger_id,
                                            // [91:40] timestamp_ticks, [151:92] timestamp_ns_q4
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // ---------------- configuration registers ----------------
  logic [PERIOD_W-1:0] period_r;
  logic [MARGIN_W-1:0] margin_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      margin_r <= MARGIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
        CFG_MARGIN: margin_r <= cfg_data[MARGIN_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------- stage handshake ----------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_ld, s2_free, s1_free, s1_adv, s2_adv;
  logic in_fire, rec_done;
  logic [2:0] pos_r;

  assign out_ld  = !out_v_r || out_tready;
  assign s2_free = !s2_v_r || out_ld;
  assign s1_free = !s1_v_r || s2_free;
  assign s1_adv  = s1_v_r && s2_free;
  assign s2_adv  = s2_v_r && out_ld;

  // Only the closing byte needs a free slot; the rest just fill assembly registers.
  assign in_tready = (pos_r != POS_LAST) || s1_free;
  assign in_fire   = in_tvalid && in_tready;
  assign rec_done  = in_fire && (pos_r == POS_LAST);

  // ---------------- record assembly ----------------
  logic [BYTE_W-1:0]   fpga_r;
  logic [RAW_ID_W-1:0] raw_id_r;
  logic [LO_W-1:0]     raw_ts_r;   // low four timestamp bytes; the fifth arrives last

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_FPGA;
    end else if (in_fire) begin
      pos_r <= pos_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpga_r   <= '0;
      raw_id_r <= '0;
      raw_ts_r <= '0;
    end else if (in_fire) begin
      case (pos_r)
        POS_FPGA:  fpga_r          <= in_tdata;
        POS_ID_LO: raw_id_r[7:0]   <= in_tdata;
        POS_ID_HI: raw_id_r[15:8]  <= in_tdata;
        POS_TS_B0: raw_ts_r[7:0]   <= in_tdata;
        POS_TS_B1: raw_ts_r[15:8]  <= in_tdata;
        POS_TS_B2: raw_ts_r[23:16] <= in_tdata;
        POS_TS_B3: raw_ts_r[31:24] <= in_tdata;
        default: ;  // last byte goes straight into the wrap logic
      endcase
    end
  end

  // ---------------- wrap tracking ----------------
  logic [RAW_TS_W-1:0]       prev_ts_r;
  logic [RAW_ID_W-1:0]       prev_id_r;
  logic [TIME_WRAP_BITS-1:0] ts_wraps_r, ts_wraps_nxt;
  logic [RAW_ID_W-1:0]       id_wraps_r, id_wraps_nxt;
  logic [RAW_TS_W-1:0]       raw_ts;
  logic [RAW_ID_W-1:0]       id_floor;
  logic                      ts_wrap, id_wrap;

  assign raw_ts   = {in_tdata, raw_ts_r};
  assign ts_wrap  = raw_ts < prev_ts_r;
  assign id_floor = prev_id_r - margin_r;
  // no id wrap while the previous id sits within the margin of zero
  assign id_wrap  = (prev_id_r > margin_r) && (raw_id_r < id_floor);

  assign ts_wraps_nxt = ts_wrap ? ts_wraps_r + TIME_WRAP_BITS'(1) : ts_wraps_r;
  assign id_wraps_nxt = id_wrap ? id_wraps_r + RAW_ID_W'(1) : id_wraps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ts_r  <= '0;
      prev_id_r  <= '0;
      ts_wraps_r <= '0;
      id_wraps_r <= '0;
    end else if (rec_done) begin
      prev_ts_r  <= raw_ts;
      prev_id_r  <= raw_id_r;
      ts_wraps_r <= ts_wraps_nxt;
      id_wraps_r <= id_wraps_nxt;
    end
  end

  // ---------------- stage 1: extended record ----------------
  logic [BYTE_W-1:0]  s1_fpga_r;
  logic [TID_W-1:0]   s1_tid_r;
  logic [TICKS_W-1:0] s1_ticks_r;

  always_ff @(posedge clk) begin
    if (rec_done) begin
      s1_fpga_r  <= fpga_r;
      s1_tid_r   <= {id_wraps_nxt, raw_id_r};
      s1_ticks_r <= TICKS_W'({ts_wraps_nxt, raw_ts});
    end
  end

  // ---------------- stage 2: partial products ----------------
  logic [BYTE_W-1:0]  s2_fpga_r;
  logic [TID_W-1:0]   s2_tid_r;
  logic [TICKS_W-1:0] s2_ticks_r;
  logic [NS_W-1:0]    s2_ns;

  tru_scale u_scale (
    .clk    (clk),
    .ld     (s1_adv),
    .ticks  (s1_ticks_r),
    .period (period_r),
    .ns_q4  (s2_ns)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_fpga_r  <= s1_fpga_r;
      s2_tid_r   <= s1_tid_r;
      s2_ticks_r <= s1_ticks_r;
    end
  end

  // ---------------- result register ----------------
  result_t out_r;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_r.fpga_id    <= s2_fpga_r;
      out_r.trigger_id <= s2_tid_r;
      out_r.ticks      <= s2_ticks_r;
      out_r.ns_q4      <= s2_ns;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rec_done)     s1_v_r <= 1'b1;
      else if (s2_free) s1_v_r <= 1'b0;

      if (s1_adv)      s2_v_r <= 1'b1;
      else if (out_ld) s2_v_r <= 1'b0;

      if (s2_adv)          out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  // ---------------- assertions ----------------
  a_rec_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
    rec_done |=> s1_v_r)
    else $error("closing byte did not load stage 1");

  a_pos_steps: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pos_r == $past(pos_r) + 3'd1)
    else $error("byte position did not advance on accepted word");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_free && !rec_done) |=> (s1_v_r && $stable(s1_ticks_r)))
    else $error("stalled stage 1 lost its record");

  a_midrecord_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != POS_LAST) |-> in_tready)
    else $error("input stalled inside a record");

endmodule
